@@ src/tusa_pkg.sv @@
// Shared types and codes for the texture unit slot allocator.
// Used by texture_unit_slot_allocator; depends on nothing.
package tusa_pkg;

  // Command codes; any code with the high bit set clears the whole table.
  localparam logic [1:0] MODE_BIND   = 2'd0;
  localparam logic [1:0] MODE_UNBIND = 2'd1;

  // Result status codes.
  localparam logic [2:0] STAT_HIT      = 3'd0;
  localparam logic [2:0] STAT_FRESH    = 3'd1;
  localparam logic [2:0] STAT_RECYCLED = 3'd2;
  localparam logic [2:0] STAT_EVICTED  = 3'd3;
  localparam logic [2:0] STAT_DEAD     = 3'd4;
  localparam logic [2:0] STAT_RELEASED = 3'd5;
  localparam logic [2:0] STAT_EMPTY    = 3'd6;
  localparam logic [2:0] STAT_CLEARED  = 3'd7;

  // One command beat.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] tex_id;
    logic        tex_alive;
    logic [3:0]  slot_sel;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [3:0]  slot_out;
    logic [2:0]  status;
    logic [31:0] evicted_id;
    logic [4:0]  used_count;
  } result_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SIMPLE,
    S_SCAN
  } state_t;

endpackage

@@ src/tusa_id_match.sv @@
// Id table of the slot allocator with its shared compare unit.
// Walks the table one entry per cycle and reports the first busy slot that holds the key.
// Depends on no package items.
module tusa_id_match #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  scan_start,
  input  logic [31:0]           key,
  input  logic [SLOT_COUNT-1:0] busy_mask,
  input  logic                  wr_en,
  input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] wr_addr,
  input  logic [31:0]           wr_data,
  output logic                  scan_done,
  output logic                  hit,
  output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] hit_slot,
  output logic [31:0]           slot0_id
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [31:0]   id_mem [SLOT_COUNT];
  logic          active;
  logic [CW-1:0] issue_cnt;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic [31:0]   rd_data;
  logic          match;

  // The compare unit looks at one registered table entry per cycle.
  assign match = rd_vld && busy_mask[rd_idx] && (rd_data == key);

  // Control: issue counter, read valid, hit flag and end of scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      issue_cnt <= '0;
      rd_vld    <= 1'b0;
      scan_done <= 1'b0;
      hit       <= 1'b0;
    end else begin
      rd_vld    <= active;
      scan_done <= rd_vld && (rd_idx == IW'(SLOT_COUNT - 1));
      if (scan_start) begin
        active    <= 1'b1;
        issue_cnt <= '0;
        hit       <= 1'b0;
      end else begin
        if (active) begin
          issue_cnt <= issue_cnt + 1'b1;
          if (issue_cnt == CW'(SLOT_COUNT - 1)) begin
            active <= 1'b0;
          end
        end
        if (match && !hit) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr] <= wr_data;
    end
    if (active) begin
      rd_data <= id_mem[issue_cnt[IW-1:0]];
      rd_idx  <= issue_cnt[IW-1:0];
    end
  end

  // Capture the first matching slot and the id held by slot 0.
  always_ff @(posedge clk) begin
    if (match && !hit) begin
      hit_slot <= rd_idx;
    end
    if (rd_vld && (rd_idx == '0)) begin
      slot0_id <= rd_data;
    end
  end

endmodule

@@ src/texture_unit_slot_allocator.sv @@
// Texture unit slot allocator: maps texture ids onto SLOT_COUNT binding slots.
// Depends on tusa_pkg and tusa_id_match.
//
// Usage: a command beat is taken on a rising edge where start is high and busy
// is low. Each command produces exactly one result beat, shown on result for a
// single cycle with strobe high; the receiver cannot stall it, so it must take
// the beat in that cycle.
// Timing: unbind, clear and a bind of a dead texture pass through S_SIMPLE and
// give a registered result; busy is low again in the cycle the strobe is high.
// A bind of a live texture walks the id table through one shared comparator,
// one slot per cycle behind a registered memory read, and no new command is
// taken until its result is out; busy stays high for the whole walk.
// Reset (rst, synchronous) empties every slot, the free stack and all counts;
// the id table and free stack memories are not cleared, since an entry is only
// read after it has been written.
module texture_unit_slot_allocator #(
  parameter int SLOT_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tusa_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              strobe,
  output tusa_pkg::result_t result
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  tusa_pkg::state_t  state, state_next;
  tusa_pkg::cmd_t    req;
  tusa_pkg::result_t result_next;

  logic [SLOT_COUNT-1:0] slot_busy, slot_busy_next;
  logic [CW-1:0]         free_depth, free_depth_next;
  logic [CW-1:0]         fresh_ptr, fresh_ptr_next;
  logic [CW-1:0]         busy_count, busy_count_next;

  logic [IW-1:0] fs_mem [SLOT_COUNT];
  logic [IW-1:0] fs_rd;
  logic          fs_we;
  logic [IW-1:0] fs_waddr;

  logic          accept;
  logic          bind_live;
  logic          scan_start;
  logic          scan_done;
  logic          hit;
  logic [IW-1:0] hit_slot;
  logic [31:0]   slot0_id;
  logic          id_we;
  logic [IW-1:0] alloc_slot;
  logic [IW-1:0] sel_idx;
  logic          sel_ok;
  logic          fire;

  assign busy       = (state != tusa_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign bind_live  = (cmd.mode == tusa_pkg::MODE_BIND) && cmd.tex_alive;
  assign scan_start = accept && bind_live;
  assign sel_idx    = IW'(req.slot_sel);
  assign sel_ok     = (32'(req.slot_sel) < SLOT_COUNT) && slot_busy[sel_idx];
  assign fs_waddr   = free_depth[IW-1:0];

  // Id table and the shared comparator that walks it.
  tusa_id_match #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .scan_start(scan_start),
    .key       (req.tex_id),
    .busy_mask (slot_busy),
    .wr_en     (id_we),
    .wr_addr   (alloc_slot),
    .wr_data   (req.tex_id),
    .scan_done (scan_done),
    .hit       (hit),
    .hit_slot  (hit_slot),
    .slot0_id  (slot0_id)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tusa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the update of slot bookkeeping for the finishing command.
  always_comb begin
    state_next      = state;
    slot_busy_next  = slot_busy;
    free_depth_next = free_depth;
    fresh_ptr_next  = fresh_ptr;
    busy_count_next = busy_count;
    result_next     = '0;
    fire            = 1'b0;
    fs_we           = 1'b0;
    id_we           = 1'b0;
    alloc_slot      = '0;
    unique case (state)
      tusa_pkg::S_IDLE: begin
        if (start) begin
          state_next = bind_live ? tusa_pkg::S_SCAN : tusa_pkg::S_SIMPLE;
        end
      end
      tusa_pkg::S_SIMPLE: begin
        state_next = tusa_pkg::S_IDLE;
        fire       = 1'b1;
        if (req.mode == tusa_pkg::MODE_BIND) begin
          result_next.status = tusa_pkg::STAT_DEAD;
        end else if (req.mode == tusa_pkg::MODE_UNBIND) begin
          if (sel_ok) begin
            slot_busy_next[sel_idx] = 1'b0;
            if (busy_count != '0) begin
              busy_count_next = busy_count - 1'b1;
            end
            if (free_depth < CW'(SLOT_COUNT)) begin
              fs_we           = 1'b1;
              free_depth_next = free_depth + 1'b1;
            end
            result_next.status = tusa_pkg::STAT_RELEASED;
          end else begin
            result_next.status = tusa_pkg::STAT_EMPTY;
          end
        end else begin
          slot_busy_next     = '0;
          free_depth_next    = '0;
          fresh_ptr_next     = '0;
          busy_count_next    = '0;
          result_next.status = tusa_pkg::STAT_CLEARED;
        end
      end
      tusa_pkg::S_SCAN: begin
        if (scan_done) begin
          state_next = tusa_pkg::S_IDLE;
          fire       = 1'b1;
          if (hit) begin
            alloc_slot         = hit_slot;
            result_next.status = tusa_pkg::STAT_HIT;
          end else if ((free_depth == '0) && (fresh_ptr >= CW'(SLOT_COUNT))) begin
            // Every slot is taken: slot 0 is handed over to the new id.
            id_we                  = 1'b1;
            alloc_slot             = '0;
            result_next.status     = tusa_pkg::STAT_EVICTED;
            result_next.evicted_id = slot0_id;
          end else if (free_depth != '0) begin
            id_we                       = 1'b1;
            alloc_slot                  = (32'(fs_rd) < SLOT_COUNT) ? fs_rd : '0;
            free_depth_next             = free_depth - 1'b1;
            slot_busy_next[alloc_slot]  = 1'b1;
            busy_count_next             = busy_count + 1'b1;
            result_next.status          = tusa_pkg::STAT_RECYCLED;
          end else begin
            id_we                       = 1'b1;
            alloc_slot                  = IW'(fresh_ptr);
            fresh_ptr_next              = fresh_ptr + 1'b1;
            slot_busy_next[alloc_slot]  = 1'b1;
            busy_count_next             = busy_count + 1'b1;
            result_next.status          = tusa_pkg::STAT_FRESH;
          end
          result_next.slot_out = 4'(alloc_slot);
        end
      end
      default: begin
        state_next = tusa_pkg::S_IDLE;
      end
    endcase
    result_next.used_count = 5'(busy_count_next);
  end

  // Slot bookkeeping and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy  <= '0;
      free_depth <= '0;
      fresh_ptr  <= '0;
      busy_count <= '0;
      strobe     <= 1'b0;
    end else begin
      slot_busy  <= slot_busy_next;
      free_depth <= free_depth_next;
      fresh_ptr  <= fresh_ptr_next;
      busy_count <= busy_count_next;
      strobe     <= fire;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= cmd;
    end
    if (fire) begin
      result <= result_next;
    end
  end

  // Free stack memory: push at the depth, registered read of the top entry.
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= sel_idx;
    end
    fs_rd <= fs_mem[IW'(free_depth - 1'b1)];
  end

`ifndef SYNTH
  // The occupied count always agrees with the occupied flags.
  assert property (@(posedge clk) disable iff (rst)
    32'(busy_count) == $countones(slot_busy))
    else $error("busy_count does not match the occupied flags");

  // Every slot ever handed out is either occupied or on the free stack.
  assert property (@(posedge clk) disable iff (rst)
    (32'(busy_count) + 32'(free_depth)) == 32'(fresh_ptr))
    else $error("slot accounting lost a slot");

  // An accepted command always makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("command accepted without going busy");

  // A result beat only follows a cycle in which a command was in progress.
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result beat without a command in progress");
`endif

endmodule
